### src/tlss_pkg.sv
package tlss_pkg;

  localparam int KIND_W  = 3;
  localparam int PAYEE_W = 56;
  localparam int COUNT_W = 7;

  localparam int DEF_SESSION_DEPTH = 64;
  localparam int DEF_PERSIST_DEPTH = 64;
  localparam int DEF_ID_BITS       = 56;

  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MARK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FORGET = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WIPE   = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PAYEE_W-1:0] dest_id;
  } in_word_t;

  typedef struct packed {
    logic               seen;
    logic [COUNT_W-1:0] session_count;
    logic [COUNT_W-1:0] persist_count;
  } out_word_t;

endpackage

### src/tlss_id_ram.sv
module tlss_id_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 56,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/two_level_seen_id_set_unit.sv
// Channel   Direction  Handshake            Word
// in_       input      in_valid/in_stall    kind, dest_id
// out_      output     out_valid/out_stall  seen, session_count, persist_count
// cfg_      input      cfg_we               persist_enabled
//
// One word at a time passes through a sequencer that scans the two id memories with a
// single comparator; each entry is read from memory, then compared.
// Reset clears the fills, the register and the control state; the memories are not cleared.
// A finished result waits in the output register while the next word is accepted.
module two_level_seen_id_set_unit #(
  parameter int SESSION_DEPTH = tlss_pkg::DEF_SESSION_DEPTH,
  parameter int PERSIST_DEPTH = tlss_pkg::DEF_PERSIST_DEPTH,
  parameter int ID_BITS       = tlss_pkg::DEF_ID_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlss_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output tlss_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  import tlss_pkg::*;

  localparam int ID_W  = (ID_BITS < PAYEE_W) ? ID_BITS : PAYEE_W;
  localparam int CWS   = $clog2(SESSION_DEPTH + 1);
  localparam int CWP   = $clog2(PERSIST_DEPTH + 1);
  localparam int IW    = (CWS > CWP) ? CWS : CWP;
  localparam int SAW   = (SESSION_DEPTH > 1) ? $clog2(SESSION_DEPTH) : 1;
  localparam int PAW   = (PERSIST_DEPTH > 1) ? $clog2(PERSIST_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SRD  = 3'd1;
  localparam logic [2:0] ST_SCMP = 3'd2;
  localparam logic [2:0] ST_FRD  = 3'd3;
  localparam logic [2:0] ST_FLD  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [KIND_W-1:0] op_r, op_nxt;
  logic [ID_W-1:0]   key_r, key_nxt;
  logic              tgt_r, tgt_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CWS-1:0]    fidx_r, fidx_nxt;
  logic [CWS-1:0]    sfill_r, sfill_nxt;
  logic [CWP-1:0]    pfill_r, pfill_nxt;
  logic              seen_r, seen_nxt;
  logic              pen_r, pen_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              s_we, s_re, p_we, p_re;
  logic [SAW-1:0]    s_raddr;
  logic [ID_W-1:0]   s_rdata, p_rdata, rd_sel;
  logic [IW-1:0]     scan_fill;
  logic              s_full, p_full, hit;

  tlss_id_ram #(.DEPTH(SESSION_DEPTH), .WIDTH(ID_W), .ADDR_W(SAW)) u_session (
    .clk   (clk),
    .we    (s_we),
    .waddr (sfill_r[SAW-1:0]),
    .wdata (key_r),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  tlss_id_ram #(.DEPTH(PERSIST_DEPTH), .WIDTH(ID_W), .ADDR_W(PAW)) u_persist (
    .clk   (clk),
    .we    (p_we),
    .waddr (pfill_r[PAW-1:0]),
    .wdata (key_r),
    .re    (p_re),
    .raddr (idx_r[PAW-1:0]),
    .rdata (p_rdata)
  );

  assign scan_fill = tgt_r ? IW'(pfill_r) : IW'(sfill_r);
  assign s_full    = (sfill_r == CWS'(SESSION_DEPTH));
  assign p_full    = (pfill_r == CWP'(PERSIST_DEPTH));
  assign rd_sel    = tgt_r ? p_rdata : s_rdata;
  assign hit       = (rd_sel == key_r);
  assign s_raddr   = (state_r == ST_FRD) ? fidx_r[SAW-1:0] : idx_r[SAW-1:0];

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    tgt_nxt       = tgt_r;
    idx_nxt       = idx_r;
    fidx_nxt      = fidx_r;
    sfill_nxt     = sfill_r;
    pfill_nxt     = pfill_r;
    seen_nxt      = seen_r;
    pen_nxt       = cfg_we ? cfg_wdata : pen_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    s_we          = 1'b0;
    p_we          = 1'b0;
    s_re          = 1'b0;
    p_re          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_word.kind;
          key_nxt  = in_word.dest_id[ID_W-1:0];
          seen_nxt = 1'b0;
          tgt_nxt  = 1'b0;
          idx_nxt  = '0;
          fidx_nxt = '0;
          case (in_word.kind)
            KIND_QUERY:  state_nxt = ST_SRD;
            KIND_MARK:   state_nxt = ST_SRD;
            KIND_FLUSH:  state_nxt = pen_r ? ST_FRD : ST_FIN;
            KIND_FORGET: begin
              sfill_nxt = '0;
              state_nxt = ST_FIN;
            end
            KIND_WIPE: begin
              sfill_nxt = '0;
              pfill_nxt = '0;
              state_nxt = ST_FIN;
            end
            default:     state_nxt = ST_FIN;
          endcase
        end
      end
      ST_SRD: begin
        if (idx_r < scan_fill) begin
          s_re      = !tgt_r;
          p_re      = tgt_r;
          state_nxt = ST_SCMP;
        end else begin
          case (op_r)
            KIND_QUERY: begin
              if (!tgt_r && pen_r) begin
                tgt_nxt   = 1'b1;
                idx_nxt   = '0;
                state_nxt = ST_SRD;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            KIND_MARK: begin
              if (!tgt_r) begin
                if (!s_full) begin
                  s_we      = 1'b1;
                  sfill_nxt = sfill_r + 1'b1;
                end
                if (pen_r) begin
                  tgt_nxt   = 1'b1;
                  idx_nxt   = '0;
                  state_nxt = ST_SRD;
                end else begin
                  state_nxt = ST_FIN;
                end
              end else begin
                if (!p_full) begin
                  p_we      = 1'b1;
                  pfill_nxt = pfill_r + 1'b1;
                end
                state_nxt = ST_FIN;
              end
            end
            KIND_FLUSH: begin
              if (!p_full) begin
                p_we      = 1'b1;
                pfill_nxt = pfill_r + 1'b1;
              end
              fidx_nxt  = fidx_r + 1'b1;
              state_nxt = ST_FRD;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_SCMP: begin
        if (hit) begin
          case (op_r)
            KIND_QUERY: begin
              seen_nxt = 1'b1;
              if (tgt_r && !s_full) begin
                s_we      = 1'b1;
                sfill_nxt = sfill_r + 1'b1;
              end
              state_nxt = ST_FIN;
            end
            KIND_MARK: begin
              if (!tgt_r && pen_r) begin
                tgt_nxt   = 1'b1;
                idx_nxt   = '0;
                state_nxt = ST_SRD;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            KIND_FLUSH: begin
              fidx_nxt  = fidx_r + 1'b1;
              state_nxt = ST_FRD;
            end
            default: state_nxt = ST_FIN;
          endcase
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SRD;
        end
      end
      ST_FRD: begin
        if (fidx_r < sfill_r) begin
          s_re      = 1'b1;
          state_nxt = ST_FLD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FLD: begin
        key_nxt   = s_rdata;
        tgt_nxt   = 1'b1;
        idx_nxt   = '0;
        state_nxt = ST_SRD;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.seen          = seen_r;
          out_word_nxt.session_count = COUNT_W'(sfill_r);
          out_word_nxt.persist_count = COUNT_W'(pfill_r);
          state_nxt                  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sfill_r     <= '0;
      pfill_r     <= '0;
      pen_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sfill_r     <= sfill_nxt;
      pfill_r     <= pfill_nxt;
      pen_r       <= pen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    tgt_r      <= tgt_nxt;
    idx_r      <= idx_nxt;
    fidx_r     <= fidx_nxt;
    seen_r     <= seen_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlss_pkg::*;

  localparam int IDLE_LIMIT = 40000;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 166;
  localparam int POOL_SIZE = 96;
  localparam logic [KIND_W-1:0] KIND_TOP = '1;
  localparam logic [PAYEE_W-1:0] ID_MASK = {PAYEE_W{1'b1}} >> (PAYEE_W - DEF_ID_BITS);

  class seen_set_scoreboard;
    logic [PAYEE_W-1:0] session_ids [DEF_SESSION_DEPTH];
    logic [PAYEE_W-1:0] persist_ids [DEF_PERSIST_DEPTH];
    int session_fill = 0;
    int persist_fill = 0;
    bit persist_on = 1'b0;
    out_word_t expected_q [$];
    int mismatches = 0;

    function bit in_session(logic [PAYEE_W-1:0] id);
      for (int i = 0; i < session_fill; i++) begin
        if (session_ids[i] == id) return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit in_persist(logic [PAYEE_W-1:0] id);
      for (int i = 0; i < persist_fill; i++) begin
        if (persist_ids[i] == id) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void add_session(logic [PAYEE_W-1:0] id);
      if (session_fill < DEF_SESSION_DEPTH && !in_session(id)) begin
        session_ids[session_fill] = id;
        session_fill++;
      end
    endfunction

    function void add_persist(logic [PAYEE_W-1:0] id);
      if (persist_fill < DEF_PERSIST_DEPTH && !in_persist(id)) begin
        persist_ids[persist_fill] = id;
        persist_fill++;
      end
    endfunction

    function void set_persist(bit on);
      persist_on = on;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // Updates the shadow sets for an accepted word and queues the word it should produce.
    function void note_word(in_word_t w);
      logic [PAYEE_W-1:0] id;
      out_word_t predicted;
      id = w.dest_id & ID_MASK;
      predicted = '0;
      case (w.kind)
        KIND_QUERY: begin
          if (in_session(id)) begin
            predicted.seen = 1'b1;
          end else if (persist_on && in_persist(id)) begin
            predicted.seen = 1'b1;
            add_session(id);
          end
        end
        KIND_MARK: begin
          add_session(id);
          if (persist_on) add_persist(id);
        end
        KIND_FLUSH: begin
          if (persist_on) begin
            for (int i = 0; i < session_fill; i++) add_persist(session_ids[i]);
          end
        end
        KIND_FORGET: begin
          session_fill = 0;
        end
        KIND_WIPE: begin
          session_fill = 0;
          persist_fill = 0;
        end
        default: begin
        end
      endcase
      predicted.session_count = COUNT_W'(session_fill);
      predicted.persist_count = COUNT_W'(persist_fill);
      expected_q.push_back(predicted);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: seen=%0d session=%0d persist=%0d",
                   got.seen, got.session_count, got.persist_count);
        return;
      end
      want = expected_q.pop_front();
      if (got.seen !== want.seen || got.session_count !== want.session_count ||
          got.persist_count !== want.persist_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected seen=%0d session=%0d persist=%0d,",
                   want.seen, want.session_count, want.persist_count,
                   " got seen=%0d session=%0d persist=%0d",
                   got.seen, got.session_count, got.persist_count);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  logic [PAYEE_W-1:0] id_pool [POOL_SIZE];
  seen_set_scoreboard book = new();

  two_level_seen_id_set_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_word(out_word);
    if (rst_n && in_valid && !in_stall) book.note_word(in_word);
    if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall)))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic drive_word(logic [KIND_W-1:0] kind, logic [PAYEE_W-1:0] id);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{kind: kind, dest_id: id};
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic write_persist(bit on);
    cfg_we <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_persist(on);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [KIND_W-1:0] pick_kind(bit calm);
    int roll;
    int forget_end;
    int wipe_end;
    roll = $urandom_range(999);
    forget_end = calm ? 924 : 965;
    wipe_end = calm ? 926 : 980;
    if (roll < 430) return KIND_QUERY;
    if (roll < 900) return KIND_MARK;
    if (roll < 920) return KIND_FLUSH;
    if (roll < forget_end) return KIND_FORGET;
    if (roll < wipe_end) return KIND_WIPE;
    if (roll < wipe_end + 10) return KIND_W'($urandom_range(KIND_WIPE + 1, KIND_TOP));
    return KIND_QUERY;
  endfunction

  // Most ids come from a small pool so that sets fill up and lookups hit.
  function automatic logic [PAYEE_W-1:0] pick_id();
    if ($urandom_range(99) < 85) return id_pool[$urandom_range(POOL_SIZE - 1)];
    return PAYEE_W'({$urandom, $urandom});
  endfunction

  initial begin
    int counted;
    bit calm;
    logic [KIND_W-1:0] kind;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = PAYEE_W'({$urandom, $urandom});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_word(KIND_QUERY, '0);
    drive_word(KIND_MARK, '0);
    drive_word(KIND_MARK, '1);
    drive_word(KIND_MARK, '1);
    drive_word(KIND_QUERY, '1);
    drive_word(KIND_QUERY, {28{2'b01}});
    drive_word(KIND_FLUSH, '0);
    drive_word(KIND_TOP, '1);
    drive_word(KIND_W'(KIND_WIPE + 1), {28{2'b10}});
    drive_word(KIND_FORGET, '0);
    drive_word(KIND_QUERY, '1);
    drain();
    write_persist(1'b1);
    drive_word(KIND_MARK, {28{2'b10}});
    drive_word(KIND_MARK, {28{2'b01}});
    drive_word(KIND_FORGET, '1);
    drive_word(KIND_QUERY, {28{2'b10}});
    drive_word(KIND_QUERY, {28{2'b10}});
    drive_word(KIND_MARK, '1);
    drive_word(KIND_FLUSH, '0);
    drive_word(KIND_QUERY, 56'h1);
    drive_word(KIND_WIPE, '0);
    drive_word(KIND_QUERY, {28{2'b01}});
    drive_word(KIND_W'(KIND_TOP - 1), '0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_persist((p % 3) != 1);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct = 22;
          recv_stall_pct = 22;
        end
      endcase
      calm = ((p / 2) % 2) == 0;
      counted = 0;
      while (counted < WORDS_PER_PHASE) begin
        kind = pick_kind(calm);
        drive_word(kind, pick_id());
        if (kind <= KIND_WIPE) counted++;
      end
    end

    drain();
    if (book.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

### filelist.f
src/tlss_pkg.sv
src/tlss_id_ram.sv
src/two_level_seen_id_set_unit.sv
tb/tb.sv
